FILE: sv/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// shared types, widths and status codes of the contiguous ring allocator
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int CAP_BITS    = OFFSET_BITS + 1;
    localparam int SIZE_BITS   = 16;
    localparam int STATUS_BITS = 2;

    localparam logic [CAP_BITS-1:0] CAP_MIN = CAP_BITS'(2);
    localparam logic [CAP_BITS-1:0] CAP_MAX = CAP_BITS'(1) << OFFSET_BITS;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_PASSED  = 2'd2;

    // request commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // classified request
    typedef struct packed {
        logic                 is_release;
        logic [SIZE_BITS-1:0] size;
    } req_t;

endpackage

FILE: sv/cra_front.sv
// ----------------------------------------------------------------------------
// cra_front
// request intake: registers and classifies, as long as the queue keeps taking them, one request per cycle
// ----------------------------------------------------------------------------
module cra_front import cra_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_command,
    input  logic [SIZE_BITS-1:0] in_size,
    output logic                 out_valid,
    input  logic                 out_ready,
    output req_t                 out_req
);

    logic valid_reg, valid_next;
    req_t req_reg;
    logic take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg.is_release <= (in_command == CMD_RELEASE);
            req_reg.size       <= in_size;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;

endmodule

FILE: sv/cra_queue.sv
// ----------------------------------------------------------------------------
// cra_queue
// short request queue decoupling intake from execution
// ----------------------------------------------------------------------------
module cra_queue import cra_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  req_t wr_req,
    output logic rd_valid,
    input  logic rd_ready,
    output req_t rd_req
);

    req_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push, pop;

    assign wr_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_req   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_req;
        end
    end

endmodule

FILE: sv/cra_back.sv
// ----------------------------------------------------------------------------
// cra_back
// executes allocate and release requests against the ring offsets
// ----------------------------------------------------------------------------
module cra_back import cra_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_fire,
    input  logic [CAP_BITS-1:0]    cfg_value,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  req_t                   q_req,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [STATUS_BITS-1:0] res_status,
    output logic [OFFSET_BITS-1:0] res_offset
);

    logic [CAP_BITS-1:0]    cap_reg, cap_next;
    logic [OFFSET_BITS-1:0] head_reg, head_next;
    logic [OFFSET_BITS-1:0] tail_reg, tail_next;
    logic [CAP_BITS-1:0]    wrap_reg, wrap_next;
    logic                   res_valid_reg, res_valid_next;
    logic [STATUS_BITS-1:0] status_reg, status_c;
    logic [OFFSET_BITS-1:0] offset_reg, offset_c;

    logic                   exec;
    logic [CAP_BITS-1:0]    size_w, head_w, tail_w;
    logic [CAP_BITS-1:0]    remain, head_end, rel_end, gap;
    logic                   fits;
    logic [CAP_BITS-1:0]    cap_sat;

    assign q_ready = !res_valid_reg || res_ready;
    assign exec    = q_valid && q_ready;

    assign size_w   = CAP_BITS'(q_req.size);
    assign head_w   = CAP_BITS'(head_reg);
    assign tail_w   = CAP_BITS'(tail_reg);
    assign remain   = (cap_reg > head_w) ? cap_reg - head_w : '0;
    assign head_end = head_w + size_w;
    assign rel_end  = tail_w + size_w;
    assign gap      = tail_w - head_w - CAP_BITS'(1);
    assign fits     = (remain >= size_w) && !((head_end == cap_reg) && (tail_reg == '0));

    // saturate the written capacity into the legal range
    always_comb begin
        cap_sat = cfg_value;
        if (cfg_value < CAP_MIN) begin
            cap_sat = CAP_MIN;
        end else if (cfg_value > CAP_MAX) begin
            cap_sat = CAP_MAX;
        end
    end

    always_comb begin
        cap_next  = cap_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        wrap_next = wrap_reg;
        status_c  = ST_OK;
        offset_c  = '0;
        if (!q_req.is_release) begin
            if (head_reg >= tail_reg) begin
                if (fits) begin
                    offset_c  = head_reg;
                    head_next = (head_end >= cap_reg) ? '0 : OFFSET_BITS'(head_end);
                end else if (size_w < tail_w) begin
                    wrap_next = head_w;
                    head_next = OFFSET_BITS'(q_req.size);
                end else begin
                    status_c = ST_NOSPACE;
                end
            end else begin
                if (gap < size_w) begin
                    status_c = ST_NOSPACE;
                end else begin
                    offset_c  = head_reg;
                    head_next = OFFSET_BITS'(head_end);
                end
            end
        end else begin
            tail_next = OFFSET_BITS'(rel_end);
            if (wrap_reg != cap_reg) begin
                if (rel_end >= wrap_reg) begin
                    if (rel_end > wrap_reg) begin
                        status_c = ST_PASSED;
                    end
                    tail_next = '0;
                    wrap_next = cap_reg;
                end
            end else if (rel_end >= cap_reg) begin
                if (rel_end > cap_reg) begin
                    status_c = ST_PASSED;
                end
                tail_next = '0;
            end
        end
        if (!exec) begin
            head_next = head_reg;
            tail_next = tail_reg;
            wrap_next = wrap_reg;
        end
        // a capacity write restarts the ring
        if (cfg_fire) begin
            cap_next  = cap_sat;
            head_next = '0;
            tail_next = '0;
            wrap_next = cap_sat;
        end
    end

    assign res_valid_next = exec ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_MAX;
            head_reg      <= '0;
            tail_reg      <= '0;
            wrap_reg      <= CAP_MAX;
            res_valid_reg <= 1'b0;
        end else begin
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wrap_reg      <= wrap_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            status_reg <= status_c;
            offset_reg <= offset_c;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = status_reg;
    assign res_offset = offset_reg;

    a_head_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        CAP_BITS'(head_reg) < cap_reg)
        else $error("allocation offset outside the store");

    a_tail_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        CAP_BITS'(tail_reg) < cap_reg)
        else $error("release offset outside the store");

    a_wrap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wrap_reg <= cap_reg)
        else $error("wrap mark beyond capacity");

    a_refusal_keeps_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && !cfg_fire && status_c == ST_NOSPACE) |=> $stable(head_reg))
        else $error("refused allocation moved the allocation offset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(status_reg)
                                          && $stable(offset_reg)))
        else $error("stalled result changed");

endmodule

FILE: sv/contiguous_ring_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_ring_allocator
// hands out contiguous regions of a circular byte store in fifo order
// ----------------------------------------------------------------------------
// requests arrive on the s_ stream: s_tuser is the command (allocate or
// release), s_tdata the byte count. every request yields exactly one result
// on the m_ stream: m_tuser carries the status (ok, no space, release passed
// boundary), m_tdata the start offset of an allocated region, else 0.
// the capacity register is written on the cfg_ channel, which is always
// ready; a write saturates the value to 2..65536 and restarts the ring, so
// it belongs only to times when no request is in flight.
// a request passes an intake register, the two-entry request queue and the
// result register. throughput is one request per cycle while m_tready
// stays high, set by the offset update in the back end.
// when the receiver stalls, the result register holds its value, the queue
// fills, and the intake keeps taking requests until the queue and the intake
// register are both full; then s_tready drops.
// reset clears all offsets, empties the queue and sets capacity to 65536.
// ----------------------------------------------------------------------------
module contiguous_ring_allocator import cra_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] size
    input  logic [0:0]          s_tuser,   // [0] command
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [15:0] offset
    output logic [1:0]          m_tuser,   // [1:0] status
    // capacity register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_BITS-1:0] cfg_wdata
);

    logic                   fr_valid, fr_ready;
    req_t                   fr_req;
    logic                   bk_valid, bk_ready;
    req_t                   bk_req;
    logic [STATUS_BITS-1:0] res_status;
    logic [OFFSET_BITS-1:0] res_offset;

    // capacity writes never stall
    assign cfg_ready = 1'b1;

    // intake and classification
    cra_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser[0]),
        .in_size    (s_tdata[SIZE_BITS-1:0]),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_req    (fr_req)
    );

    // decoupling queue
    cra_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_req   (fr_req),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_req   (bk_req)
    );

    // offset bookkeeping and result register
    cra_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_fire   (cfg_valid && cfg_ready),
        .cfg_value  (cfg_wdata),
        .q_valid    (bk_valid),
        .q_ready    (bk_ready),
        .q_req      (bk_req),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_offset (res_offset)
    );

    assign m_tuser = res_status;
    assign m_tdata = 16'(res_offset);

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the contiguous ring allocator
// ----------------------------------------------------------------------------
// allocate and release requests go in on the s_ stream. each accepted request
// is run through a cycle-free model of the ring (allocation offset, release
// offset, wrap mark), and the result it should give is queued. a monitor
// compares every result on the m_ stream against the oldest queued one.
// directed tests cover full-ring corners, wrapping and capacity saturation.
// random traffic then runs fifo-ordered alloc/release sequences with some
// malformed requests mixed in, at several capacities and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import cra_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 8;     // margin over the pipeline latency

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [15:0]            offset;
    } alloc_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // [15:0] size
    logic [0:0]          s_tuser;   // [0] command
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;   // [15:0] offset
    logic [1:0]          m_tuser;   // [1:0] status
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_wdata;

    contiguous_ring_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    // model state of the ring
    logic [CAP_BITS-1:0] ring_cap;      // effective capacity after saturation
    logic [CAP_BITS-1:0] ring_head;     // next allocation offset
    logic [CAP_BITS-1:0] ring_tail;     // release offset
    logic [CAP_BITS-1:0] ring_wrap;     // wrap mark, equals ring_cap when not wrapped

    alloc_result_t       pending_results[$];
    logic [15:0]         live_regions[$];   // sizes of regions still held
    int                  error_count  = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  quiet_cycles   = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // ring model
    // ------------------------------------------------------------------------
    // capacity write saturates and restarts the ring
    function automatic void load_capacity(input logic [CAP_BITS-1:0] value);
        if (value < CAP_MIN)
            ring_cap = CAP_MIN;
        else if (value > CAP_MAX)
            ring_cap = CAP_MAX;
        else
            ring_cap = value;
        ring_head = '0;
        ring_tail = '0;
        ring_wrap = ring_cap;
    endfunction

    function automatic alloc_result_t ring_predict(input logic cmd, input logic [15:0] size);
        alloc_result_t       res;
        logic [CAP_BITS:0]   sum;
        logic [CAP_BITS-1:0] room;
        logic                fits;
        res.status = ST_OK;
        res.offset = '0;
        if (cmd == CMD_ALLOC) begin
            if (ring_head >= ring_tail) begin
                // free space runs from head to the end of the store
                room = (ring_cap > ring_head) ? ring_cap - ring_head : '0;
                fits = (room >= size);
                sum  = ring_head + size;
                // filling to the end with tail at 0 would look empty
                if (fits && sum == ring_cap && ring_tail == '0)
                    fits = 1'b0;
                if (fits) begin
                    res.offset = ring_head[15:0];
                    ring_head  = (sum >= ring_cap) ? '0 : sum[CAP_BITS-1:0];
                end else if (size < ring_tail) begin
                    // wrap to the start, keeping one byte in front of tail
                    ring_wrap = ring_head;
                    ring_head = CAP_BITS'(size);
                end else begin
                    res.status = ST_NOSPACE;
                end
            end else begin
                // already wrapped: free space lies between head and tail
                if (ring_tail - ring_head - 1 < size) begin
                    res.status = ST_NOSPACE;
                end else begin
                    res.offset = ring_head[15:0];
                    ring_head  = ring_head + size;
                end
            end
        end else begin
            sum = ring_tail + size;
            if (ring_wrap != ring_cap) begin
                if (sum >= ring_wrap) begin
                    if (sum > ring_wrap)
                        res.status = ST_PASSED;
                    sum       = '0;
                    ring_wrap = ring_cap;
                end
            end else if (sum >= ring_cap) begin
                if (sum > ring_cap)
                    res.status = ST_PASSED;
                sum = '0;
            end
            ring_tail = sum[CAP_BITS-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random back-pressure and checking
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d offset %0d",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata !== want.offset) begin
                    $display("%0t: offset mismatch: expected %0d actual %0d",
                             $time, want.offset, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // entered and left at a falling edge; s_tvalid is left high so the caller
    // decides at that same edge whether the next request follows at once
    task automatic send_request(input logic cmd, input logic [15:0] size,
                                output alloc_result_t res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= size;
        do
            @(posedge aclk);
        while (!s_tready);
        res = ring_predict(cmd, size);
        pending_results.push_back(res);
        @(negedge aclk);
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        load_capacity(value);
        live_regions.delete();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    // mostly fifo-ordered alloc/release, some malformed requests
    task automatic run_traffic(input int count);
        alloc_result_t res;
        logic          cmd;
        logic [15:0]   size;
        logic          refused;
        int            cap_i;
        refused = 1'b0;
        for (int i = 0; i < count; i++) begin
            cap_i = int'(ring_cap);
            if ($urandom_range(0, 99) < 12) begin
                // malformed: any command, sizes that need not match a region
                cmd  = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    size = 16'($urandom_range(0, 65535));
                else
                    size = 16'($urandom_range(0, (cap_i + 2 > 65535) ? 65535 : cap_i + 2));
                send_request(cmd, size, res);
            end else if (live_regions.size() == 0
                         || (!refused && $urandom_range(0, 99) < 55)) begin
                cmd = CMD_ALLOC;
                if ($urandom_range(0, 9) == 0)
                    size = 16'($urandom_range(1, cap_i - 1));
                else
                    size = 16'($urandom_range(1, cap_i / 2));
                send_request(cmd, size, res);
                refused = (res.status == ST_NOSPACE);
                if (res.status == ST_OK)
                    live_regions.push_back(size);
            end else begin
                // release the oldest region held
                cmd  = CMD_RELEASE;
                size = live_regions.pop_front();
                send_request(cmd, size, res);
                refused = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // full-size store: zero-size alloc, full-looks-empty refusal, exact end,
    // release past allocated data and release past capacity
    task automatic test_full_ring_corners();
        alloc_result_t res;
        send_request(CMD_ALLOC,   16'd0,     res);
        send_request(CMD_ALLOC,   16'd65535, res);
        send_request(CMD_ALLOC,   16'd1,     res);
        send_request(CMD_RELEASE, 16'd65535, res);
        send_request(CMD_ALLOC,   16'd1,     res);
        send_request(CMD_ALLOC,   16'd100,   res);
        send_request(CMD_RELEASE, 16'd1,     res);
        send_request(CMD_RELEASE, 16'd200,   res);
        send_request(CMD_RELEASE, 16'd65535, res);
    endtask

    // small store: wrap to start, no space while wrapped, release at the
    // wrap mark, release passing the wrap mark
    task automatic test_wrap_around();
        alloc_result_t res;
        write_capacity(CAP_BITS'(16));
        send_request(CMD_ALLOC,   16'd10, res);
        send_request(CMD_RELEASE, 16'd4,  res);
        send_request(CMD_ALLOC,   16'd8,  res);
        send_request(CMD_ALLOC,   16'd3,  res);
        send_request(CMD_ALLOC,   16'd2,  res);
        send_request(CMD_ALLOC,   16'd3,  res);
        send_request(CMD_ALLOC,   16'd1,  res);
        send_request(CMD_RELEASE, 16'd6,  res);
        send_request(CMD_RELEASE, 16'd5,  res);
        send_request(CMD_ALLOC,   16'd12, res);
        send_request(CMD_RELEASE, 16'd3,  res);
        send_request(CMD_ALLOC,   16'd4,  res);
        send_request(CMD_ALLOC,   16'd2,  res);
        send_request(CMD_RELEASE, 16'd20, res);
    endtask

    // register values below and above the legal range saturate
    task automatic test_capacity_saturation();
        alloc_result_t res;
        write_capacity('0);
        send_request(CMD_ALLOC,   16'd1, res);
        send_request(CMD_ALLOC,   16'd1, res);
        send_request(CMD_RELEASE, 16'd1, res);
        send_request(CMD_ALLOC,   16'd1, res);
        write_capacity('1);
        send_request(CMD_ALLOC,   16'd65535, res);
    endtask

    // random traffic over a spread of capacities and idle patterns
    task automatic test_random_traffic();
        logic [CAP_BITS-1:0] caps[9];
        caps = '{CAP_BITS'(16), CAP_BITS'(3), CAP_BITS'(255), CAP_BITS'(1000),
                 CAP_BITS'(2), CAP_MAX, CAP_BITS'(64), CAP_BITS'(1), CAP_BITS'(500)};
        for (int k = 0; k < 9; k++) begin
            write_capacity(caps[k]);
            set_idling(k);
            run_traffic(135);
        end
        write_capacity(CAP_BITS'($urandom_range(2, 300)));
        set_idling(0);
        run_traffic(60);
    endtask

    // sender holds off mid-stream until every result has come back
    task automatic test_drain_pause();
        write_capacity(CAP_BITS'(40));
        set_idling(3);
        run_traffic(50);
        drain_requests();
        run_traffic(50);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_wdata = '0;
        load_capacity(CAP_MAX);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_full_ring_corners();
        test_wrap_around();
        test_capacity_saturation();
        test_random_traffic();
        test_drain_pause();

        drain_requests();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/cra_pkg.sv
sv/cra_front.sv
sv/cra_queue.sv
sv/cra_back.sv
sv/contiguous_ring_allocator.sv
bench/tb_top.sv
